/* hw/rtl/fjt_pkg.sv */
// Shared types, constants and codes of the frame jank tracker.
// Used by every module of the block; depends on nothing.
package fjt_pkg;

    localparam int WINDOW_FRAMES = 64;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 20;
    localparam int WIN_W    = 11;
    localparam int CNT_W    = 32;
    localparam int PCT_W    = 7;
    localparam int PROD_W   = CNT_W + PCT_W;

    localparam int DIV_N_W   = TIME_W + 1;
    localparam int DIV_D_W   = CNT_W;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 136;

    localparam int PCT_SCALE = 100;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_WINDOW  = 2'd1;
    localparam logic [1:0] KIND_SCROLL  = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_REJECT = 2'd1,
        OP_SCROLL = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  janky;
        logic                  avail;
        logic [DIV_N_W-1:0]    dividend;
        logic [PERIOD_W-1:0]   divisor;
    } op_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_res_t;

endpackage

/* hw/rtl/fjt_front.sv */
// Front end: takes input transfers, checks frame timing, classifies the frame.
// Owns the previous present/input times; pushes operations to fjt_queue. Uses fjt_pkg.
module fjt_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_input_time, last_input_time, present_time, vsync_period, zero pad
    input  logic [fjt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [1:0]                       s_tuser,
    input  fjt_pkg::q_status_t               q_stat,
    output logic                             push,
    output fjt_pkg::op_entry_t               push_entry
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_CHECK = 3'b010,
        F_PUSH  = 3'b100
    } f_state_t;

    localparam int TW = fjt_pkg::TIME_W;
    localparam int PW = fjt_pkg::PERIOD_W;

    f_state_t f_state_reg, f_state_next;

    logic [1:0]     cmd_reg;
    logic [TW-1:0]  first_reg, last_reg, pres_reg;
    logic [PW-1:0]  period_reg;
    logic [TW-1:0]  prev_pres_reg, prev_pres_next;
    logic [TW-1:0]  prev_last_reg, prev_last_next;
    fjt_pkg::op_t   op_reg, op_next;
    logic [TW-1:0]  gap_reg;
    logic [TW:0]    diff_reg;
    logic [PW-1:0]  per_reg;

    logic           accept;
    logic           reject;
    logic [PW-1:0]  half;
    logic [PW:0]    limit;

    assign s_tready = (f_state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign reject = (last_reg < first_reg) || (pres_reg <= last_reg) ||
                    (pres_reg <= prev_pres_reg);

    assign half  = {1'b0, per_reg[PW-1:1]};
    assign limit = {1'b0, per_reg} + {1'b0, half};

    always_comb begin
        f_state_next   = f_state_reg;
        prev_pres_next = prev_pres_reg;
        prev_last_next = prev_last_reg;
        op_next        = op_reg;
        push           = 1'b0;
        unique case (f_state_reg)
            F_IDLE: begin
                if (accept) begin
                    f_state_next = F_CHECK;
                end
            end
            F_CHECK: begin
                unique case (cmd_reg)
                    fjt_pkg::CMD_FRAME: begin
                        f_state_next = F_PUSH;
                        if (reject) begin
                            op_next = fjt_pkg::OP_REJECT;
                        end else begin
                            op_next        = fjt_pkg::OP_FRAME;
                            prev_pres_next = pres_reg;
                            prev_last_next = last_reg;
                        end
                    end
                    fjt_pkg::CMD_SCROLL: begin
                        op_next      = fjt_pkg::OP_SCROLL;
                        f_state_next = F_PUSH;
                    end
                    fjt_pkg::CMD_FLUSH: begin
                        op_next      = fjt_pkg::OP_FLUSH;
                        f_state_next = F_PUSH;
                    end
                    default: begin
                        f_state_next = F_IDLE;
                    end
                endcase
            end
            F_PUSH: begin
                if (!q_stat.full) begin
                    push         = 1'b1;
                    f_state_next = F_IDLE;
                end
            end
            default: begin
                f_state_next = F_IDLE;
            end
        endcase
    end

    always_comb begin
        push_entry.op       = op_reg;
        push_entry.janky    = (gap_reg > {{(TW-PW-1){1'b0}}, limit}) &&
                              (diff_reg[TW] ||
                               (diff_reg[TW-1:0] < {{(TW-PW-1){1'b0}}, limit}));
        push_entry.avail    = diff_reg[TW] ||
                              (diff_reg[TW-1:0] < {{(TW-PW-1){1'b0}}, limit});
        push_entry.dividend = {1'b0, gap_reg} + {{(TW+1-PW){1'b0}}, half};
        push_entry.divisor  = per_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_state_reg   <= F_IDLE;
            prev_pres_reg <= '0;
            prev_last_reg <= '0;
            op_reg        <= fjt_pkg::OP_FRAME;
        end else begin
            f_state_reg   <= f_state_next;
            prev_pres_reg <= prev_pres_next;
            prev_last_reg <= prev_last_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tuser;
            first_reg  <= s_tdata[TW-1:0];
            last_reg   <= s_tdata[2*TW-1:TW];
            pres_reg   <= s_tdata[3*TW-1:2*TW];
            period_reg <= s_tdata[3*TW+PW-1:3*TW];
        end
        if (f_state_reg == F_CHECK) begin
            gap_reg  <= pres_reg - prev_pres_reg;
            diff_reg <= {1'b0, first_reg} - {1'b0, prev_last_reg};
            per_reg  <= (period_reg == '0) ? {{(PW-1){1'b0}}, 1'b1} : period_reg;
        end
    end

endmodule

/* hw/rtl/fjt_queue.sv */
// Short operation queue between the front end and the back end.
// Register-based FIFO of fjt_pkg::op_entry_t; uses fjt_pkg.
module fjt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fjt_pkg::op_entry_t  push_entry,
    input  logic                pop,
    output fjt_pkg::op_entry_t  head,
    output fjt_pkg::q_status_t  stat
);

    localparam int AW = fjt_pkg::QUEUE_AW;

    fjt_pkg::op_entry_t entries [fjt_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign head       = entries[rd_ptr_reg];
    assign stat.full  = (count_reg == (AW+1)'(fjt_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/fjt_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Request and result travel as fjt_pkg::div_req_t / div_res_t; uses fjt_pkg.
module fjt_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  fjt_pkg::div_req_t  req,
    output fjt_pkg::div_res_t  res
);

    localparam int NW = fjt_pkg::DIV_N_W;
    localparam int DW = fjt_pkg::DIV_D_W;
    localparam int CW = fjt_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    assign res.busy     = busy_reg;
    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(fjt_pkg::DIV_STEPS);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

/* hw/rtl/fjt_back.sv */
// Back end: pops operations, divides, updates window and scroll counters,
// drives the registered result channel. Instantiates fjt_divider; uses fjt_pkg.
module fjt_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fjt_pkg::op_entry_t                q_head,
    input  fjt_pkg::q_status_t                q_stat,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // janky, frame_missed_vsyncs, counted_vsyncs, delayed_percent,
    // missed_vsyncs_sum, missed_vsyncs_max
    output logic [fjt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // kind
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    typedef enum logic [4:0] {
        B_IDLE       = 5'b00001,
        B_DIV_FRAME  = 5'b00010,
        B_FRAME_OUT  = 5'b00100,
        B_WIN_OUT    = 5'b01000,
        B_DIV_SCROLL = 5'b10000
    } b_state_t;

    localparam int CW = fjt_pkg::CNT_W;
    localparam int WW = fjt_pkg::WIN_W;
    localparam int NW = fjt_pkg::DIV_N_W;
    localparam int PW = fjt_pkg::PCT_W;
    localparam int XW = fjt_pkg::PROD_W;

    function automatic logic [CW-1:0] sat32(input logic [NW-1:0] v);
        return (|v[NW-1:CW]) ? {CW{1'b1}} : v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_add32(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    b_state_t state_reg, state_next;

    fjt_pkg::op_t  cur_op_reg, cur_op_next;
    logic          cur_janky_reg, cur_janky_next;
    logic          cur_avail_reg, cur_avail_next;
    logic [CW-1:0] counted_reg, counted_next;
    logic [CW-1:0] miss_reg, miss_next;

    logic [WW-1:0] win_frames_reg, win_frames_next;
    logic [WW-1:0] win_delayed_reg, win_delayed_next;
    logic [CW-1:0] win_sum_reg, win_sum_next;
    logic [CW-1:0] win_max_reg, win_max_next;
    logic          scroll_open_reg, scroll_open_next;
    logic [CW-1:0] scroll_frames_reg, scroll_frames_next;
    logic [CW-1:0] scroll_delayed_reg, scroll_delayed_next;
    logic [CW-1:0] scroll_sum_reg, scroll_sum_next;
    logic [CW-1:0] scroll_max_reg, scroll_max_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_kind_reg;
    logic          m_last_reg;
    logic [fjt_pkg::OUT_TDATA_W-1:0] m_data_reg;

    fjt_pkg::div_req_t div_req;
    fjt_pkg::div_res_t div_res;

    logic          out_free;
    logic          out_load;
    logic [1:0]    out_kind;
    logic          out_last;
    logic          out_janky;
    logic [CW-1:0] out_fmiss, out_counted, out_sum, out_max;
    logic [PW-1:0] out_pct;

    logic [CW-1:0] mul_src;
    logic [XW-1:0] product;
    logic [PW-1:0] pct;
    logic [XW-1:0] win_quo;
    logic [PW-1:0] win_pct;
    logic [NW-1:0] total_m1;
    logic [WW-1:0] win_inc;
    logic          win_hit;
    logic [CW-1:0] sc_frames_base, sc_delayed_base, sc_sum_base, sc_max_base;

    fjt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign mul_src  = (state_reg == B_WIN_OUT) ? {{(CW-WW){1'b0}}, win_delayed_reg}
                                               : scroll_delayed_reg;
    assign product  = {{PW{1'b0}}, mul_src} * XW'(fjt_pkg::PCT_SCALE);
    assign pct      = (div_res.quotient > {{(NW-PW){1'b0}}, fjt_pkg::PCT_MAX}) ?
                      fjt_pkg::PCT_MAX : div_res.quotient[PW-1:0];
    // window size is a power of two: the division is a shift
    assign win_quo  = product / XW'(fjt_pkg::WINDOW_FRAMES);
    assign win_pct  = (win_quo > {{(XW-PW){1'b0}}, fjt_pkg::PCT_MAX}) ?
                      fjt_pkg::PCT_MAX : win_quo[PW-1:0];
    assign total_m1 = div_res.quotient - {{(NW-1){1'b0}}, 1'b1};
    assign win_inc  = win_frames_reg + 1'b1;
    assign win_hit  = (win_inc == WW'(fjt_pkg::WINDOW_FRAMES));

    assign sc_frames_base  = scroll_open_reg ? scroll_frames_reg  : '0;
    assign sc_delayed_base = scroll_open_reg ? scroll_delayed_reg : '0;
    assign sc_sum_base     = scroll_open_reg ? scroll_sum_reg     : '0;
    assign sc_max_base     = scroll_open_reg ? scroll_max_reg     : '0;

    always_comb begin
        state_next          = state_reg;
        q_pop               = 1'b0;
        div_req.start       = 1'b0;
        div_req.dividend    = {{(NW-XW){1'b0}}, product};
        div_req.divisor     = scroll_frames_reg;
        cur_op_next         = cur_op_reg;
        cur_janky_next      = cur_janky_reg;
        cur_avail_next      = cur_avail_reg;
        counted_next        = counted_reg;
        miss_next           = miss_reg;
        win_frames_next     = win_frames_reg;
        win_delayed_next    = win_delayed_reg;
        win_sum_next        = win_sum_reg;
        win_max_next        = win_max_reg;
        scroll_open_next    = scroll_open_reg;
        scroll_frames_next  = scroll_frames_reg;
        scroll_delayed_next = scroll_delayed_reg;
        scroll_sum_next     = scroll_sum_reg;
        scroll_max_next     = scroll_max_reg;
        out_load            = 1'b0;
        out_kind            = fjt_pkg::KIND_VERDICT;
        out_last            = 1'b0;
        out_janky           = 1'b0;
        out_fmiss           = '0;
        out_counted         = '0;
        out_pct             = '0;
        out_sum             = '0;
        out_max             = '0;

        unique case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    unique case (q_head.op)
                        fjt_pkg::OP_FRAME: begin
                            q_pop            = 1'b1;
                            div_req.start    = 1'b1;
                            div_req.dividend = q_head.dividend;
                            div_req.divisor  = {{(CW-fjt_pkg::PERIOD_W){1'b0}},
                                                q_head.divisor};
                            cur_janky_next   = q_head.janky;
                            cur_avail_next   = q_head.avail;
                            state_next       = B_DIV_FRAME;
                        end
                        fjt_pkg::OP_REJECT: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                out_load = 1'b1;
                                out_kind = fjt_pkg::KIND_REJECT;
                                out_last = 1'b1;
                            end
                        end
                        fjt_pkg::OP_SCROLL, fjt_pkg::OP_FLUSH: begin
                            q_pop       = 1'b1;
                            cur_op_next = q_head.op;
                            if (scroll_open_reg && (scroll_frames_reg != '0)) begin
                                div_req.start = 1'b1;
                                state_next    = B_DIV_SCROLL;
                            end else begin
                                scroll_open_next    = (q_head.op == fjt_pkg::OP_SCROLL);
                                scroll_frames_next  = '0;
                                scroll_delayed_next = '0;
                                scroll_sum_next     = '0;
                                scroll_max_next     = '0;
                            end
                        end
                    endcase
                end
            end
            B_DIV_FRAME: begin
                if (div_res.done) begin
                    counted_next = cur_avail_reg ? sat32(div_res.quotient)
                                                 : {{(CW-1){1'b0}}, 1'b1};
                    miss_next    = cur_janky_reg ? sat32(total_m1) : '0;
                    state_next   = B_FRAME_OUT;
                end
            end
            B_FRAME_OUT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_kind    = fjt_pkg::KIND_VERDICT;
                    out_last    = !win_hit;
                    out_janky   = cur_janky_reg;
                    out_fmiss   = miss_reg;
                    out_counted = counted_reg;

                    scroll_open_next    = 1'b1;
                    scroll_frames_next  = sat_add32(sc_frames_base, {{(CW-1){1'b0}}, 1'b1});
                    scroll_delayed_next = sc_delayed_base;
                    scroll_sum_next     = sc_sum_base;
                    scroll_max_next     = sc_max_base;
                    if (cur_janky_reg) begin
                        scroll_delayed_next = sat_add32(sc_delayed_base,
                                                        {{(CW-1){1'b0}}, 1'b1});
                        scroll_sum_next     = sat_add32(sc_sum_base, miss_reg);
                        scroll_max_next     = (miss_reg > sc_max_base) ? miss_reg
                                                                       : sc_max_base;
                        win_delayed_next    = win_delayed_reg + 1'b1;
                        win_sum_next        = sat_add32(win_sum_reg, miss_reg);
                        win_max_next        = (miss_reg > win_max_reg) ? miss_reg
                                                                       : win_max_reg;
                    end
                    win_frames_next = win_hit ? '0 : win_inc;
                    state_next      = win_hit ? B_WIN_OUT : B_IDLE;
                end
            end
            B_WIN_OUT: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_kind         = fjt_pkg::KIND_WINDOW;
                    out_last         = 1'b1;
                    out_pct          = win_pct;
                    out_sum          = win_sum_reg;
                    out_max          = win_max_reg;
                    win_delayed_next = '0;
                    win_sum_next     = '0;
                    win_max_next     = '0;
                    state_next       = B_IDLE;
                end
            end
            B_DIV_SCROLL: begin
                if (div_res.done && out_free) begin
                    out_load            = 1'b1;
                    out_kind            = fjt_pkg::KIND_SCROLL;
                    out_last            = 1'b1;
                    out_pct             = pct;
                    out_sum             = scroll_sum_reg;
                    out_max             = scroll_max_reg;
                    scroll_open_next    = (cur_op_reg == fjt_pkg::OP_SCROLL);
                    scroll_frames_next  = '0;
                    scroll_delayed_next = '0;
                    scroll_sum_next     = '0;
                    scroll_max_next     = '0;
                    state_next          = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= B_IDLE;
            m_valid_reg        <= 1'b0;
            win_frames_reg     <= '1;
            win_delayed_reg    <= '0;
            win_sum_reg        <= '0;
            win_max_reg        <= '0;
            scroll_open_reg    <= 1'b0;
            scroll_frames_reg  <= '0;
            scroll_delayed_reg <= '0;
            scroll_sum_reg     <= '0;
            scroll_max_reg     <= '0;
        end else begin
            state_reg          <= state_next;
            m_valid_reg        <= m_valid_next;
            win_frames_reg     <= win_frames_next;
            win_delayed_reg    <= win_delayed_next;
            win_sum_reg        <= win_sum_next;
            win_max_reg        <= win_max_next;
            scroll_open_reg    <= scroll_open_next;
            scroll_frames_reg  <= scroll_frames_next;
            scroll_delayed_reg <= scroll_delayed_next;
            scroll_sum_reg     <= scroll_sum_next;
            scroll_max_reg     <= scroll_max_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_op_reg    <= cur_op_next;
        cur_janky_reg <= cur_janky_next;
        cur_avail_reg <= cur_avail_next;
        counted_reg   <= counted_next;
        miss_reg      <= miss_next;
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_last_reg <= out_last;
            m_data_reg <= {out_max, out_sum, out_pct, out_counted, out_fmiss, out_janky};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_res.busy)
        else $error("divider restarted while busy");

    a_window_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        win_frames_reg != WW'(fjt_pkg::WINDOW_FRAMES))
        else $error("window frame count not wrapped");

    a_scroll_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        scroll_delayed_reg <= scroll_frames_reg)
        else $error("scroll delayed frames exceed frames");

    a_window_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FRAME_OUT) && out_load && !out_last |=> state_reg == B_WIN_OUT)
        else $error("window summary not scheduled after verdict");
`endif

endmodule

/* hw/rtl/frame_jank_tracker_unit.sv */
// Top level of the frame jank tracker: front end, operation queue, back end.
// Depends on fjt_pkg, fjt_front, fjt_queue, fjt_back (which holds fjt_divider).
//
//  Channel | Ports            | tdata (low bit up)                        | tuser | tlast
//  --------+------------------+-------------------------------------------+-------+------
//  input   | s_tvalid/tready  | first_input_time, last_input_time,        | cmd   | -
//          |                  | present_time, vsync_period, pad to 168    |       |
//  result  | m_tvalid/tready  | janky, frame_missed_vsyncs, counted_vsyncs,| kind  | last
//          |                  | delayed_percent, missed_vsyncs_sum, _max  |       |
//
// The 49-step restoring divider sets the rate: each frame and each scroll summary waits for it,
// a frame that closes a window adds a window summary, and a rejection skips the divider.
// The front end takes a new transfer once the last one is pushed, until the 4-entry queue fills.
// Reset (aresetn low, synchronous) opens no scroll and clears all counters but the window frame count (all ones).
// A stalled result channel holds the back end; the front end keeps filling the queue.
module frame_jank_tracker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_input_time, last_input_time, present_time, vsync_period, zero pad
    input  logic [fjt_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // janky, frame_missed_vsyncs, counted_vsyncs, delayed_percent,
    // missed_vsyncs_sum, missed_vsyncs_max
    output logic [fjt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // kind
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    fjt_pkg::q_status_t q_stat;
    fjt_pkg::op_entry_t push_entry;
    fjt_pkg::op_entry_t q_head;
    logic               push;
    logic               q_pop;

    fjt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    fjt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    fjt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
